// ----- src/assert_macros.svh -----
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RPWM_ASSERT(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("rpwm assertion failed");
`define RPWM_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rpwm implication failed");
`else
`define RPWM_ASSERT(name, clk, rstn, expr)
`define RPWM_ASSERT_IMP(name, clk, rstn, ante, cons)
`endif
`endif

// ----- src/rpwm_pkg.sv -----
// Shared types and constants of the repetition pattern window matcher.
`default_nettype none
package rpwm_pkg;
  localparam int MAX_LEN_DEF  = 64;
  localparam int WORD_IDS_DEF = 65536;
  localparam int WORD_W  = 16;
  localparam int POS_W   = 32;
  localparam int EPOCH_W = 16;

  typedef enum logic [1:0] {
    OP_PAT_BEGIN = 2'd0,
    OP_PAT_WORD  = 2'd1,
    OP_REC_BEGIN = 2'd2,
    OP_SRC_WORD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DEC, S_MOD, S_READ, S_CALC, S_MATCH, S_WRAP
  } state_t;

  typedef struct packed {
    logic load;
    logic op_en;
    logic mod_start;
    logic mod_step;
    logic rd_en;
    logic calc_en;
    logic match_en;
    logic clr_we;
    logic wrap_fix;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic pat_full;
    logic wrap;
    logic clr_last;
    logic mod_last;
  } stat_t;
endpackage
`default_nettype wire

// ----- src/rpwm_ctrl.sv -----
// Controller state machine of the matcher.
`default_nettype none
`include "assert_macros.svh"
module rpwm_ctrl
  import rpwm_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire       out_ready,
  input  var stat_t stat,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;
  logic   outq_r, outq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      outq_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outq_r  <= outq_nxt;
    end
  end

  // next state; a finished item waits in outq_r until taken
  always_comb begin
    state_nxt = state_r;
    outq_nxt  = outq_r;
    if (outq_r && out_ready) begin
      outq_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !outq_r) state_nxt = S_DEC;
      end
      S_DEC: begin
        case (stat.op)
          OP_PAT_BEGIN, OP_REC_BEGIN: begin
            if (stat.wrap) begin
              state_nxt = S_WRAP;
            end else begin
              state_nxt = S_IDLE;
              outq_nxt  = 1'b1;
            end
          end
          OP_PAT_WORD: begin
            if (stat.pat_full) begin
              state_nxt = S_IDLE;
              outq_nxt  = 1'b1;
            end else begin
              state_nxt = S_MOD;
            end
          end
          default: state_nxt = S_MOD;
        endcase
      end
      S_MOD: begin
        if (stat.mod_last) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_CALC;
      S_CALC: begin
        if (stat.op == OP_PAT_WORD) begin
          state_nxt = S_IDLE;
          outq_nxt  = 1'b1;
        end else begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_IDLE;
        outq_nxt  = 1'b1;
      end
      S_WRAP: begin
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
          outq_nxt  = 1'b1;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = (state_r == S_IDLE) && !outq_r;
    out_valid = outq_r;
    case (state_r)
      S_CLEAR: cmd.clr_we = 1'b1;
      S_IDLE:  cmd.load = in_valid && !outq_r;
      S_DEC: begin
        cmd.op_en     = 1'b1;
        cmd.mod_start = 1'b1;
      end
      S_MOD:   cmd.mod_step = 1'b1;
      S_READ:  cmd.rd_en = 1'b1;
      S_CALC:  cmd.calc_en = 1'b1;
      S_MATCH: cmd.match_en = 1'b1;
      S_WRAP: begin
        cmd.clr_we   = 1'b1;
        cmd.wrap_fix = stat.clr_last;
      end
      default: cmd = '0;
    endcase
  end

  `RPWM_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, cmd.clr_we, !in_ready)
  `RPWM_ASSERT_IMP(a_calc_not_full, clk, rst_n, cmd.calc_en && stat.op == OP_PAT_WORD, !stat.pat_full)
  `RPWM_ASSERT_IMP(a_out_holds, clk, rst_n, out_valid && !out_ready, ##1 out_valid)
endmodule
`default_nettype wire

// ----- src/rpwm_dp.sv -----
// Datapath: last-seen table, id reduction, pattern and history cells.
`default_nettype none
`include "assert_macros.svh"
module rpwm_dp
  import rpwm_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int WORD_IDS = WORD_IDS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [1:0]          in_opcode,
  input  wire  [WORD_W-1:0]   in_word,
  input  var cmd_t            cmd,
  output stat_t               stat,
  output logic                match_found,
  output logic [POS_W-1:0]    record_index,
  output logic [POS_W-1:0]    match_start,
  output logic                pattern_overflow
);
  localparam int DW = $clog2(MAX_LEN + 1);
  localparam int IW = (WORD_IDS > 1) ? $clog2(WORD_IDS) : 1;
  localparam int CW = 1;
  localparam int EW = EPOCH_W + POS_W;
  localparam int PW = WORD_W + POS_W;
  localparam logic [POS_W-1:0] RECIP = POS_W'((64'd1 << POS_W) / WORD_IDS);

  op_t               op_r;
  logic [WORD_W-1:0] wsh_r;
  logic [WORD_W-1:0] q_r;
  logic [IW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     mcnt_r;
  logic [IW-1:0]     clr_addr_r;
  logic [EW-1:0]     mem [WORD_IDS];
  logic [EW-1:0]     rd_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  rcnt_r;
  logic [DW-1:0]     plen_r;
  logic              ovf_r;
  logic [DW-1:0]     dist_r;
  logic [DW-1:0]     hist_r [MAX_LEN];
  logic [DW-1:0]     rpat_r [MAX_LEN];
  logic              found_r;
  logic [POS_W-1:0]  start_r;

  logic              full;
  logic [PW-1:0]     prod, rfull;
  logic [POS_W-1:0]  epos, gap;
  logic [DW-1:0]     enc_dist;
  logic              tag_hit;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  logic [EW-1:0]     mem_wd;
  logic              fresh;
  logic [DW-1:0]     nh [MAX_LEN];
  logic [MAX_LEN-1:0] cell_ok;
  logic [POS_W-1:0]  npos;
  logic              win_ok;

  assign full = (plen_r == DW'(MAX_LEN));

  assign stat.op       = op_r;
  assign stat.pat_full = full;
  assign stat.wrap     = (epoch_r == {EPOCH_W{1'b1}});
  assign stat.clr_last = (clr_addr_r == IW'(WORD_IDS - 1));
  assign stat.mod_last = (mcnt_r == CW'(1));

  // reduce the id modulo the table depth: reciprocal estimate, then one correction
  always_comb begin
    prod  = PW'(wsh_r) * PW'(RECIP);
    rfull = PW'(wsh_r) - PW'(q_r) * PW'(WORD_IDS);
    if (rfull >= PW'(WORD_IDS)) rfull = rfull - PW'(WORD_IDS);
    rem_nxt = rfull[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_opcode);
      wsh_r <= in_word;
    end
    if (cmd.mod_start) begin
      rem_r  <= '0;
      mcnt_r <= '0;
    end else if (cmd.mod_step) begin
      if (mcnt_r == '0) begin
        q_r <= prod[PW-1:POS_W];
      end else begin
        rem_r <= rem_nxt;
      end
      mcnt_r <= mcnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_we) begin
      clr_addr_r <= stat.clr_last ? '0 : clr_addr_r + IW'(1);
    end
  end

  // encode: distance back to the last occurrence, saturated
  always_comb begin
    epos     = (op_r == OP_PAT_WORD) ? POS_W'(plen_r) : pos_r;
    gap      = epos - rd_r[POS_W-1:0];
    tag_hit  = (epoch_r != '0) && (rd_r[EW-1:POS_W] == epoch_r);
    enc_dist = '0;
    if (tag_hit) begin
      enc_dist = (gap > POS_W'(MAX_LEN)) ? DW'(MAX_LEN) : gap[DW-1:0];
    end
  end

  assign mem_we = cmd.clr_we || cmd.calc_en;
  assign mem_wa = cmd.clr_we ? clr_addr_r : rem_r;
  assign mem_wd = cmd.clr_we ? '0 : {epoch_r, epos};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd_en) rd_r <= mem[rem_r];
  end

  assign fresh = cmd.op_en && (op_r == OP_PAT_BEGIN || op_r == OP_REC_BEGIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= '0;
      pos_r   <= '0;
      rcnt_r  <= '0;
      plen_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (fresh) begin
        epoch_r <= epoch_r + EPOCH_W'(1);
        pos_r   <= '0;
      end else if (cmd.wrap_fix) begin
        epoch_r <= EPOCH_W'(1);
      end else if (cmd.match_en) begin
        pos_r <= npos;
      end
      if (cmd.op_en && op_r == OP_PAT_BEGIN) begin
        rcnt_r <= '0;
        plen_r <= '0;
        ovf_r  <= 1'b0;
      end else if (cmd.op_en && op_r == OP_REC_BEGIN) begin
        rcnt_r <= rcnt_r + POS_W'(1);
      end else if (cmd.op_en && op_r == OP_PAT_WORD && full) begin
        ovf_r <= 1'b1;
      end else if (cmd.calc_en && op_r == OP_PAT_WORD) begin
        plen_r <= plen_r + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_en) dist_r <= enc_dist;
  end

  // reversed pattern line: tap 0 holds the newest pattern word
  always_ff @(posedge clk) begin
    if (cmd.calc_en && op_r == OP_PAT_WORD) begin
      rpat_r[0] <= enc_dist;
      for (int i = 1; i < MAX_LEN; i++) rpat_r[i] <= rpat_r[i-1];
    end
  end

  always_comb begin
    nh[0] = dist_r;
    for (int i = 1; i < MAX_LEN; i++) nh[i] = hist_r[i-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || fresh) begin
      for (int i = 0; i < MAX_LEN; i++) hist_r[i] <= '0;
    end else if (cmd.match_en) begin
      for (int i = 0; i < MAX_LEN; i++) hist_r[i] <= nh[i];
    end
  end

  // one comparator cell per window position
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      if (DW'(i) >= plen_r) begin
        cell_ok[i] = 1'b1;
      end else if (rpat_r[i] != '0) begin
        cell_ok[i] = (nh[i] == rpat_r[i]);
      end else begin
        cell_ok[i] = (nh[i] == '0) ||
                     (({1'b0, nh[i]} + (DW+1)'(i)) >= {1'b0, plen_r});
      end
    end
  end

  assign npos   = pos_r + POS_W'(1);
  assign win_ok = (plen_r != '0) && (npos >= POS_W'(plen_r)) && (&cell_ok);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r <= 1'b0;
      start_r <= '0;
    end else if (cmd.match_en && win_ok) begin
      found_r <= 1'b1;
      start_r <= npos - POS_W'(plen_r);
    end
  end

  assign match_found      = found_r;
  assign match_start      = start_r;
  assign record_index     = rcnt_r - POS_W'(1);
  assign pattern_overflow = ovf_r;

  `RPWM_ASSERT(a_plen_bound, clk, rst_n, plen_r <= DW'(MAX_LEN))
  `RPWM_ASSERT_IMP(a_match_no_empty, clk, rst_n, cmd.match_en && win_ok, plen_r != '0)
  `RPWM_ASSERT_IMP(a_wrap_zero_epoch, clk, rst_n, cmd.wrap_fix, epoch_r == '0)
endmodule
`default_nettype wire

// ----- src/repetition_pattern_window_matcher_unit.sv -----
// Top level of the repetition pattern window matcher.
// From accept to result: a source word passes through decode, id reduction, table read,
// encode and compare; a pattern word skips compare; a begin item or dropped pattern word only decodes.
// Throughput: one item in flight; the next item is taken the cycle after its result leaves.
// A begin item that wraps the epoch sweeps the whole table before its result.
// Reset: synchronous, active low; then the table clears, with in_tready low.
`default_nettype none
module repetition_pattern_window_matcher_unit
  import rpwm_pkg::*;
#(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int WORD_IDS = WORD_IDS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [15:0] word_id
  input  wire  [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // [31:0] record_index, [63:32] match_start
  output logic [1:0]  out_tuser   // [0] match_found, [1] pattern_overflow
);
  cmd_t  cmd;
  stat_t stat;
  logic  found, ovf;
  logic [POS_W-1:0] rec_idx, start;

  // sequence each word item through reduce, read, encode and, for a source word, compare
  rpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpwm_dp #(
    .MAX_LEN  (MAX_LEN),
    .WORD_IDS (WORD_IDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_tuser),
    .in_word          (in_tdata),
    .cmd              (cmd),
    .stat             (stat),
    .match_found      (found),
    .record_index     (rec_idx),
    .match_start      (start),
    .pattern_overflow (ovf)
  );

  assign out_tdata = {start, rec_idx};
  assign out_tuser = {ovf, found};
endmodule
`default_nettype wire
